// File: rtl/core/i64alu_pkg.sv
package i64alu_pkg;

   localparam int unsigned DataWidth  = 64;
   localparam int unsigned HalfWidth  = 32;
   localparam int unsigned DivSteps   = 64;
   localparam int unsigned KindWidth  = 5;
   localparam int unsigned ShiftWidth = 7;

   typedef enum logic [KindWidth-1:0] {
      KIND_ADD    = 5'd0,
      KIND_SUB    = 5'd1,
      KIND_MUL    = 5'd2,
      KIND_UMUL32 = 5'd3,
      KIND_SMUL32 = 5'd4,
      KIND_UDIV   = 5'd5,
      KIND_SDIV   = 5'd6,
      KIND_UREM   = 5'd7,
      KIND_SREM   = 5'd8,
      KIND_AND    = 5'd9,
      KIND_OR     = 5'd10,
      KIND_XOR    = 5'd11,
      KIND_SHL    = 5'd12,
      KIND_SHR    = 5'd13,
      KIND_ASHR   = 5'd14,
      KIND_SEXT32 = 5'd15,
      KIND_PACK   = 5'd16,
      KIND_HI     = 5'd17
   } kind_type;

   // Payload that runs through the divider stages. Items that do not divide
   // carry their finished result in quo and pass the stages untouched.
   typedef struct packed {
      logic                 is_div;
      logic                 want_rem;
      logic                 negate;
      logic                 div_zero;
      logic [DataWidth-1:0] rem;
      logic [DataWidth-1:0] quo;
      logic [DataWidth-1:0] divisor;
   } stage_type;

endpackage

// File: rtl/core/i64alu_front.sv
module i64alu_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  logic                                valid_in,
   input  i64alu_pkg::kind_type                kind,
   input  logic [i64alu_pkg::DataWidth-1:0]    operand_a,
   input  logic [i64alu_pkg::DataWidth-1:0]    operand_b,
   input  logic [i64alu_pkg::ShiftWidth-1:0]   shift_amount,
   output logic                                valid_out,
   output i64alu_pkg::stage_type               stage_out
);

   typedef struct packed {
      i64alu_pkg::kind_type                   kind;
      logic [i64alu_pkg::DataWidth-1:0]       simple;
      logic [i64alu_pkg::DataWidth-1:0]       pp_ll;
      logic [i64alu_pkg::HalfWidth-1:0]       pp_lh;
      logic [i64alu_pkg::HalfWidth-1:0]       pp_hl;
      logic [i64alu_pkg::HalfWidth-1:0]       a_lo;
      logic [i64alu_pkg::HalfWidth-1:0]       b_lo;
      logic [i64alu_pkg::DataWidth-1:0]       ma;
      logic [i64alu_pkg::DataWidth-1:0]       mb;
      logic                                   na;
      logic                                   nb;
      logic                                   b_zero;
   } pre_type;

   pre_type                          pre_in, pre_ff;
   logic                             valid1_ff;
   i64alu_pkg::stage_type            stage_in, stage_ff;
   logic                             valid2_ff;
   logic [i64alu_pkg::DataWidth-1:0] prod_lh, prod_hl;
   logic [i64alu_pkg::DataWidth-1:0] sa_lo, sb_lo;
   logic                             signed_div;

   always_comb begin
      prod_lh = operand_a[31:0] * operand_b[63:32];
      prod_hl = operand_a[63:32] * operand_b[31:0];
      sa_lo   = {{32{operand_a[31]}}, operand_a[31:0]};
      signed_div = (kind == i64alu_pkg::KIND_SDIV) || (kind == i64alu_pkg::KIND_SREM);

      pre_in.kind   = kind;
      pre_in.pp_ll  = operand_a[31:0] * operand_b[31:0];
      pre_in.pp_lh  = prod_lh[31:0];
      pre_in.pp_hl  = prod_hl[31:0];
      pre_in.a_lo   = operand_a[31:0];
      pre_in.b_lo   = operand_b[31:0];
      pre_in.na     = signed_div && operand_a[63];
      pre_in.nb     = signed_div && operand_b[63];
      pre_in.ma     = pre_in.na ? (64'd0 - operand_a) : operand_a;
      pre_in.mb     = pre_in.nb ? (64'd0 - operand_b) : operand_b;
      pre_in.b_zero = (operand_b == 64'd0);

      case (kind)
         i64alu_pkg::KIND_ADD:    pre_in.simple = operand_a + operand_b;
         i64alu_pkg::KIND_SUB:    pre_in.simple = operand_a - operand_b;
         i64alu_pkg::KIND_AND:    pre_in.simple = operand_a & operand_b;
         i64alu_pkg::KIND_OR:     pre_in.simple = operand_a | operand_b;
         i64alu_pkg::KIND_XOR:    pre_in.simple = operand_a ^ operand_b;
         i64alu_pkg::KIND_SHL:
            pre_in.simple = shift_amount[6] ? 64'd0 : (operand_a << shift_amount[5:0]);
         i64alu_pkg::KIND_SHR:
            pre_in.simple = shift_amount[6] ? 64'd0 : (operand_a >> shift_amount[5:0]);
         i64alu_pkg::KIND_ASHR:
            pre_in.simple = shift_amount[6] ? {64{operand_a[63]}}
                          : 64'($signed(operand_a) >>> shift_amount[5:0]);
         i64alu_pkg::KIND_SEXT32: pre_in.simple = sa_lo;
         i64alu_pkg::KIND_PACK:   pre_in.simple = {operand_a[31:0], operand_b[31:0]};
         i64alu_pkg::KIND_HI:     pre_in.simple = {32'd0, operand_a[63:32]};
         default:                 pre_in.simple = 64'd0;
      endcase
   end

   // Second stage: sum the partial products and set up the divider.
   always_comb begin
      sb_lo = 64'd0;
      stage_in.is_div   = 1'b0;
      stage_in.want_rem = 1'b0;
      stage_in.negate   = 1'b0;
      stage_in.div_zero = 1'b0;
      stage_in.rem      = 64'd0;
      stage_in.divisor  = pre_ff.mb;
      stage_in.quo      = pre_ff.simple;
      case (pre_ff.kind) inside
         i64alu_pkg::KIND_MUL:
            stage_in.quo = pre_ff.pp_ll + {pre_ff.pp_lh + pre_ff.pp_hl, 32'd0};
         i64alu_pkg::KIND_UMUL32:
            stage_in.quo = pre_ff.pp_ll;
         i64alu_pkg::KIND_SMUL32: begin
            sb_lo = (pre_ff.a_lo[31] ? {pre_ff.b_lo, 32'd0} : 64'd0)
                  + (pre_ff.b_lo[31] ? {pre_ff.a_lo, 32'd0} : 64'd0);
            stage_in.quo = pre_ff.pp_ll - sb_lo;
         end
         i64alu_pkg::KIND_UDIV, i64alu_pkg::KIND_UREM,
         i64alu_pkg::KIND_SDIV, i64alu_pkg::KIND_SREM: begin
            stage_in.is_div   = 1'b1;
            stage_in.div_zero = pre_ff.b_zero;
            stage_in.quo      = pre_ff.ma;
            stage_in.want_rem = (pre_ff.kind == i64alu_pkg::KIND_UREM)
                             || (pre_ff.kind == i64alu_pkg::KIND_SREM);
            stage_in.negate   = stage_in.want_rem ? pre_ff.na : (pre_ff.na ^ pre_ff.nb);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else if (advance) begin
         valid1_ff <= valid_in;
         valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pre_ff   <= pre_in;
         stage_ff <= stage_in;
      end
   end

   assign valid_out = valid2_ff;
   assign stage_out = stage_ff;

endmodule

// File: rtl/core/i64alu_div_step.sv
module i64alu_div_step (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   valid_in,
   input  i64alu_pkg::stage_type  stage_in,
   output logic                   valid_out,
   output i64alu_pkg::stage_type  stage_out
);

   i64alu_pkg::stage_type  step_in, step_ff;
   logic                   valid_ff;
   logic [64:0]            trial;
   logic [64:0]            diff;

   // One restoring step: shift the next dividend bit into the remainder.
   always_comb begin
      trial   = {stage_in.rem, stage_in.quo[63]};
      diff    = trial - {1'b0, stage_in.divisor};
      step_in = stage_in;
      if (stage_in.is_div) begin
         if (!diff[64]) begin
            step_in.rem = diff[63:0];
            step_in.quo = {stage_in.quo[62:0], 1'b1};
         end else begin
            step_in.rem = trial[63:0];
            step_in.quo = {stage_in.quo[62:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         step_ff <= step_in;
      end
   end

   assign valid_out = valid_ff;
   assign stage_out = step_ff;

endmodule

// File: rtl/core/i64alu_back.sv
module i64alu_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic                              valid_in,
   input  i64alu_pkg::stage_type             stage_in,
   output logic                              valid_out,
   output logic [i64alu_pkg::DataWidth-1:0]  result,
   output logic                              is_zero,
   output logic                              is_negative,
   output logic                              divide_by_zero
);

   logic [i64alu_pkg::DataWidth-1:0] pick, result_in, result_ff;
   logic                             dz_in, dz_ff, valid_ff;

   always_comb begin
      pick      = stage_in.want_rem ? stage_in.rem : stage_in.quo;
      result_in = stage_in.quo;
      dz_in     = 1'b0;
      if (stage_in.is_div) begin
         dz_in = stage_in.div_zero;
         if (stage_in.div_zero) begin
            result_in = 64'd0;
         end else begin
            result_in = stage_in.negate ? (64'd0 - pick) : pick;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
         dz_ff     <= dz_in;
      end
   end

   assign valid_out      = valid_ff;
   assign result         = result_ff;
   assign is_zero        = (result_ff == 64'd0);
   assign is_negative    = result_ff[63];
   assign divide_by_zero = dz_ff;

endmodule

// File: rtl/core/int64_alu_core.sv
// 64-bit integer ALU, fully pipelined: one transfer is accepted every cycle while
// the pipeline is not held, and every operation passes through the same stages.
// The depth is set by the divider, a chain of 64 restoring stages that
// produce one quotient bit each; two front stages decode and form the
// multiply partial products, and one back stage fixes signs and flags.
// The whole pipeline holds while a result waits on rsp_tready.
module int64_alu_core (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // kind[4:0], operand_a[68:5], operand_b[132:69], shift_amount[139:133], zero pad
   input  logic [143:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // result[63:0], is_zero[64], is_negative[65], divide_by_zero[66], zero pad
   output logic [71:0]   rsp_tdata
);

   logic                   advance;
   logic                   front_valid;
   i64alu_pkg::stage_type  front_stage;
   logic                   step_valid [i64alu_pkg::DivSteps+1];
   i64alu_pkg::stage_type  step_stage [i64alu_pkg::DivSteps+1];
   logic [63:0]            result;
   logic                   is_zero, is_negative, divide_by_zero;

   // Advance everything unless the held result is not taken.
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   i64alu_front u_front (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .valid_in     (req_tvalid),
      .kind         (i64alu_pkg::kind_type'(req_tdata[4:0])),
      .operand_a    (req_tdata[68:5]),
      .operand_b    (req_tdata[132:69]),
      .shift_amount (req_tdata[139:133]),
      .valid_out    (front_valid),
      .stage_out    (front_stage)
   );

   assign step_valid[0] = front_valid;
   assign step_stage[0] = front_stage;

   for (genvar i = 0; i < i64alu_pkg::DivSteps; i++) begin : g_div
      i64alu_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .valid_in  (step_valid[i]),
         .stage_in  (step_stage[i]),
         .valid_out (step_valid[i+1]),
         .stage_out (step_stage[i+1])
      );
   end

   i64alu_back u_back (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .valid_in       (step_valid[i64alu_pkg::DivSteps]),
      .stage_in       (step_stage[i64alu_pkg::DivSteps]),
      .valid_out      (rsp_tvalid),
      .result         (result),
      .is_zero        (is_zero),
      .is_negative    (is_negative),
      .divide_by_zero (divide_by_zero)
   );

   assign rsp_tdata = {5'd0, divide_by_zero, is_negative, is_zero, result};

`ifndef SYNTH
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && divide_by_zero |-> result == 64'd0)
      else $error("divide by zero with nonzero result");

   a_zero_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> is_zero == (result == 64'd0))
      else $error("zero flag mismatch");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");
`endif

endmodule
